// ===== hdl/lpbc_pkg.sv =====
// Shared types, constants and the fade lookup table for the LED pattern controller.
package lpbc_pkg;

  localparam int unsigned FADE_PERIOD_MS = 2000;
  localparam int unsigned LED_COUNT      = 3;
  localparam int unsigned NUM_LEDS       = 3;
  localparam int unsigned PH_W           = $clog2(FADE_PERIOD_MS);
  localparam int unsigned LIT_W          = (LED_COUNT > 2) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned GAP_W          = 11;
  localparam logic [GAP_W-1:0] GAP_SAT   = GAP_W'(1024);
  localparam logic [15:0] CNT_MAX        = 16'hFFFF;
  localparam logic [7:0]  DUTY_ON        = 8'hFF;
  localparam logic [7:0]  DUTY_OFF       = 8'h00;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 16;

  typedef enum logic [1:0] {
    MODE_DARK = 2'd0,
    MODE_ALT  = 2'd1,
    MODE_FULL = 2'd2,
    MODE_SINE = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_LONG     = 2'd1,
    CFG_BLINK    = 2'd2,
    CFG_BUZZ     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [9:0]  debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] blink_interval_ms;
    logic [15:0] buzz_ms;
  } cfg_t;

  // Packed so that mode_pressed sits in bit 0.
  typedef struct packed {
    logic reset_pressed;
    logic action_pressed;
    logic mode_pressed;
  } tick_t;

  // Packed so that red_duty sits in the lowest byte.
  typedef struct packed {
    logic        override_active;
    logic [1:0]  current_mode;
    logic        buzzer_on;
    logic [7:0]  yellow_duty;
    logic [7:0]  green_duty;
    logic [7:0]  red_duty;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);

  typedef logic [7:0] fade_tbl_t [FADE_PERIOD_MS];

  // Duty of one LED at a phase, from the fixed point quarter sine.
  function automatic logic [7:0] fade_duty(int unsigned p);
    logic [63:0] a;
    logic [63:0] q;
    logic [63:0] f;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] u;
    a  = (64'(p) * 64'd131072) / FADE_PERIOD_MS;
    q  = (a >> 15) & 64'd3;
    f  = a & 64'd32767;
    z  = q[0] ? (64'd32768 - f) : f;
    z2 = (z * z) >> 15;
    t  = (64'd2320 * z2) >> 15;
    t  = ((64'd21024 - t) * z2) >> 15;
    s  = ((64'd51472 - t) * z) >> 15;
    u  = q[1] ? (64'd32768 - s) : (64'd32768 + s);
    return 8'((u * 64'd255) >> 16);
  endfunction

  function automatic fade_tbl_t build_fade_tbl();
    fade_tbl_t tbl;
    for (int unsigned i = 0; i < FADE_PERIOD_MS; i++) begin
      tbl[i] = fade_duty(i);
    end
    return tbl;
  endfunction

  localparam fade_tbl_t FADE_TBL = build_fade_tbl();

  // Phase offsets of a third and two thirds of a period, rounded.
  localparam logic [PH_W-1:0] FADE_OFF [NUM_LEDS] = '{
    PH_W'(0),
    PH_W'((2 * FADE_PERIOD_MS + 3) / 6),
    PH_W'((4 * FADE_PERIOD_MS + 3) / 6)
  };

  // Duties at phase zero, used on the tick that enters fade mode and on each wrap of the phase.
  localparam logic [7:0] FADE_START [NUM_LEDS] = '{
    FADE_TBL[FADE_OFF[0]],
    FADE_TBL[FADE_OFF[1]],
    FADE_TBL[FADE_OFF[2]]
  };

endpackage

// ===== hdl/led_pattern_button_controller.sv =====
// Top level of the LED pattern and button controller.
// Each request on the input stream is one millisecond tick with three button levels; the block
// answers every tick with exactly one result (three LED duties, buzzer flag, mode, override
// flag). A tick is taken in every clock cycle: the whole update is combinational from the state
// registers into a result register, and a skid stage behind it keeps input ready while only one
// result waits downstream. Fade duties come from three copies of a 2000-entry duty ROM whose
// registered reads are addressed one phase ahead of the current one. Configuration is written
// through the plain write port; the user must do so while no tick is in flight (not enforced).
module led_pattern_button_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // mode_pressed, action_pressed, reset_pressed
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [31:0]                     m_axis_tdata,  // red_duty, green_duty, yellow_duty,
                                                         // buzzer_on, current_mode, override_active
  input  logic                            cfg_we_i,
  input  logic [lpbc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lpbc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  lpbc_pkg::cfg_t  cfg;
  lpbc_pkg::tick_t tick;
  lpbc_pkg::res_t  res_new;
  lpbc_pkg::res_t  res_out;
  logic            tick_acc;

  assign tick     = lpbc_pkg::tick_t'(s_axis_tdata[2:0]);
  assign tick_acc = s_axis_tvalid && s_axis_tready;

  lpbc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  lpbc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_acc_i (tick_acc),
    .tick_i     (tick),
    .cfg_i      (cfg),
    .res_o      (res_new)
  );

  lpbc_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (tick_acc),
    .res_i       (res_new),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .res_o       (res_out)
  );

  assign m_axis_tdata = {(32 - lpbc_pkg::RES_W)'(0), res_out};

endmodule

// ===== hdl/lpbc_fade_rom.sv =====
// Fade duty ROM with one registered read port.
module lpbc_fade_rom (
  input  logic                     clk_i,
  input  logic [lpbc_pkg::PH_W-1:0] addr_i,
  output logic [7:0]               data_o
);

  logic [7:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= lpbc_pkg::FADE_TBL[addr_i];
  end

  assign data_o = data_q;

endmodule

// ===== hdl/lpbc_cfg_regs.sv =====
// Configuration registers written through the plain write port.
module lpbc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [lpbc_pkg::CFG_IDX_W-1:0] index_i,
  input  logic [lpbc_pkg::CFG_DATA_W-1:0] wdata_i,
  output lpbc_pkg::cfg_t                cfg_o
);

  lpbc_pkg::cfg_t cfg_q;
  lpbc_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (lpbc_pkg::cfg_idx_e'(index_i))
        lpbc_pkg::CFG_DEBOUNCE: cfg_d.debounce_ms       = wdata_i[9:0];
        lpbc_pkg::CFG_LONG:     cfg_d.long_press_ms     = wdata_i;
        lpbc_pkg::CFG_BLINK:    cfg_d.blink_interval_ms = wdata_i;
        lpbc_pkg::CFG_BUZZ:     cfg_d.buzz_ms           = wdata_i;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms       <= 10'd50;
      cfg_q.long_press_ms     <= 16'd1500;
      cfg_q.blink_interval_ms <= 16'd400;
      cfg_q.buzz_ms           <= 16'd300;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/lpbc_core.sv =====
// Per-tick state update: buttons, modes, blink, fade and buzzer.
module lpbc_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           tick_acc_i,
  input  lpbc_pkg::tick_t tick_i,
  input  lpbc_pkg::cfg_t  cfg_i,
  output lpbc_pkg::res_t  res_o
);

  localparam int unsigned PH_W  = lpbc_pkg::PH_W;
  localparam int unsigned LIT_W = lpbc_pkg::LIT_W;
  localparam int unsigned GAP_W = lpbc_pkg::GAP_W;
  localparam int unsigned NL    = lpbc_pkg::NUM_LEDS;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(lpbc_pkg::FADE_PERIOD_MS - 1);
  localparam logic [PH_W:0]   PH_PER  = (PH_W + 1)'(lpbc_pkg::FADE_PERIOD_MS);
  localparam logic [LIT_W-1:0] LIT_LAST = LIT_W'(lpbc_pkg::LED_COUNT - 1);

  lpbc_pkg::mode_e  mode_q, mode_d;
  logic             man_en_q, man_en_d;
  logic             man_lvl_q, man_lvl_d;
  logic             blink_ph_q, blink_ph_d;
  logic [LIT_W-1:0] lit_q, lit_d;
  logic [15:0]      blink_cnt_q, blink_cnt_d;
  logic [PH_W-1:0]  fade_ph_q, fade_ph_d;
  logic [15:0]      hold_cnt_q, hold_cnt_d;
  logic             held_q, held_d;
  logic             long_done_q, long_done_d;
  logic             mode_wait_q, mode_wait_d;
  logic             rst_wait_q, rst_wait_d;
  logic [GAP_W-1:0] mode_gap_q, mode_gap_d;
  logic [GAP_W-1:0] rst_gap_q, rst_gap_d;
  logic [15:0]      buzz_cnt_q, buzz_cnt_d;
  logic [7:0]       duty_q [NL];
  logic [7:0]       duty_d [NL];

  logic [PH_W-1:0]  rom_base;
  logic [PH_W-1:0]  rom_src;
  logic [PH_W:0]    rom_sum  [NL];
  logic [PH_W-1:0]  rom_addr [NL];
  logic [7:0]       rom_data [NL];

  // Tick update, in the same order as the buttons are handled.
  always_comb begin
    mode_d      = mode_q;
    man_en_d    = man_en_q;
    man_lvl_d   = man_lvl_q;
    blink_ph_d  = blink_ph_q;
    lit_d       = lit_q;
    held_d      = held_q;
    long_done_d = long_done_q;
    mode_wait_d = mode_wait_q;
    rst_wait_d  = rst_wait_q;
    duty_d      = duty_q;

    mode_gap_d  = (mode_gap_q < lpbc_pkg::GAP_SAT) ? mode_gap_q + 1'b1 : mode_gap_q;
    rst_gap_d   = (rst_gap_q < lpbc_pkg::GAP_SAT) ? rst_gap_q + 1'b1 : rst_gap_q;
    blink_cnt_d = (blink_cnt_q != lpbc_pkg::CNT_MAX) ? blink_cnt_q + 16'd1 : blink_cnt_q;
    fade_ph_d   = (fade_ph_q == PH_LAST) ? '0 : fade_ph_q + 1'b1;
    hold_cnt_d  = (held_q && hold_cnt_q != lpbc_pkg::CNT_MAX) ? hold_cnt_q + 16'd1
                                                              : hold_cnt_q;
    buzz_cnt_d  = (buzz_cnt_q != '0) ? buzz_cnt_q - 16'd1 : buzz_cnt_q;

    // mode button
    if (mode_wait_q) begin
      if (!tick_i.mode_pressed) begin
        mode_wait_d = 1'b0;
        mode_gap_d  = '0;
      end
    end else if (tick_i.mode_pressed && mode_gap_d > {1'b0, cfg_i.debounce_ms}) begin
      mode_wait_d = 1'b1;
      mode_d      = lpbc_pkg::mode_e'(mode_q + 2'd1);
      man_en_d    = 1'b0;
      unique case (mode_d)
        lpbc_pkg::MODE_DARK: duty_d = '{default: lpbc_pkg::DUTY_OFF};
        lpbc_pkg::MODE_ALT: begin
          blink_cnt_d = '0;
          blink_ph_d  = 1'b0;
        end
        lpbc_pkg::MODE_FULL: duty_d = '{default: lpbc_pkg::DUTY_ON};
        lpbc_pkg::MODE_SINE: fade_ph_d = '0;
        default:             duty_d = duty_q;
      endcase
    end

    // reset button: always lands in off
    if (rst_wait_q) begin
      if (!tick_i.reset_pressed) begin
        rst_wait_d = 1'b0;
        rst_gap_d  = '0;
      end
    end else if (tick_i.reset_pressed && rst_gap_d > {1'b0, cfg_i.debounce_ms}) begin
      rst_wait_d = 1'b1;
      mode_d     = lpbc_pkg::MODE_DARK;
      man_en_d   = 1'b0;
      duty_d     = '{default: lpbc_pkg::DUTY_OFF};
    end

    // action button
    if (tick_i.action_pressed && !held_q) begin
      held_d      = 1'b1;
      hold_cnt_d  = '0;
      long_done_d = 1'b0;
    end
    if (tick_i.action_pressed && held_d && !long_done_d &&
        hold_cnt_d >= cfg_i.long_press_ms) begin
      long_done_d = 1'b1;
      buzz_cnt_d  = cfg_i.buzz_ms;
    end
    if (!tick_i.action_pressed && held_q) begin
      held_d = 1'b0;
      if (!long_done_d && hold_cnt_d < cfg_i.long_press_ms) begin
        man_en_d  = 1'b1;
        man_lvl_d = !man_lvl_q;
        duty_d    = '{default: (man_lvl_d ? lpbc_pkg::DUTY_ON : lpbc_pkg::DUTY_OFF)};
      end
    end

    // mode behavior
    if (!man_en_d) begin
      if (mode_d == lpbc_pkg::MODE_ALT) begin
        if (blink_cnt_d >= cfg_i.blink_interval_ms) begin
          blink_cnt_d = '0;
          blink_ph_d  = !blink_ph_d;
          if (blink_ph_d) begin
            lit_d = (lit_q == LIT_LAST) ? '0 : lit_q + 1'b1;
            for (int k = 0; k < NL; k++) begin
              duty_d[k] = (int'(lit_d) == k) ? lpbc_pkg::DUTY_ON : lpbc_pkg::DUTY_OFF;
            end
          end else begin
            duty_d = '{default: lpbc_pkg::DUTY_OFF};
          end
        end
      end else if (mode_d == lpbc_pkg::MODE_SINE) begin
        for (int k = 0; k < NL; k++) begin
          duty_d[k] = (fade_ph_d == '0) ? lpbc_pkg::FADE_START[k] : rom_data[k];
        end
      end
    end
  end

  // The ROMs always hold the duties for the phase after the current one.
  assign rom_src  = tick_acc_i ? fade_ph_d : fade_ph_q;
  assign rom_base = (rom_src == PH_LAST) ? '0 : rom_src + 1'b1;

  for (genvar g = 0; g < NL; g++) begin : g_rom
    always_comb begin
      rom_sum[g]  = {1'b0, rom_base} + {1'b0, lpbc_pkg::FADE_OFF[g]};
      rom_addr[g] = (rom_sum[g] >= PH_PER) ? PH_W'(rom_sum[g] - PH_PER)
                                           : rom_sum[g][PH_W-1:0];
    end

    lpbc_fade_rom u_rom (
      .clk_i  (clk_i),
      .addr_i (rom_addr[g]),
      .data_o (rom_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= lpbc_pkg::MODE_DARK;
      man_en_q    <= 1'b0;
      man_lvl_q   <= 1'b0;
      blink_ph_q  <= 1'b0;
      lit_q       <= '0;
      blink_cnt_q <= '0;
      fade_ph_q   <= '0;
      hold_cnt_q  <= '0;
      held_q      <= 1'b0;
      long_done_q <= 1'b0;
      mode_wait_q <= 1'b0;
      rst_wait_q  <= 1'b0;
      mode_gap_q  <= lpbc_pkg::GAP_SAT;
      rst_gap_q   <= lpbc_pkg::GAP_SAT;
      buzz_cnt_q  <= '0;
      duty_q      <= '{default: lpbc_pkg::DUTY_OFF};
    end else if (tick_acc_i) begin
      mode_q      <= mode_d;
      man_en_q    <= man_en_d;
      man_lvl_q   <= man_lvl_d;
      blink_ph_q  <= blink_ph_d;
      lit_q       <= lit_d;
      blink_cnt_q <= blink_cnt_d;
      fade_ph_q   <= fade_ph_d;
      hold_cnt_q  <= hold_cnt_d;
      held_q      <= held_d;
      long_done_q <= long_done_d;
      mode_wait_q <= mode_wait_d;
      rst_wait_q  <= rst_wait_d;
      mode_gap_q  <= mode_gap_d;
      rst_gap_q   <= rst_gap_d;
      buzz_cnt_q  <= buzz_cnt_d;
      duty_q      <= duty_d;
    end
  end

  always_comb begin
    res_o.red_duty        = duty_d[0];
    res_o.green_duty      = duty_d[1];
    res_o.yellow_duty     = duty_d[2];
    res_o.buzzer_on       = (buzz_cnt_d != '0);
    res_o.current_mode    = mode_d;
    res_o.override_active = man_en_d;
  end

  a_gap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_gap_q <= lpbc_pkg::GAP_SAT && rst_gap_q <= lpbc_pkg::GAP_SAT)
    else $error("release gap ran past saturation");

  a_fade_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fade_ph_q <= PH_LAST)
    else $error("fade phase out of period");

  a_lit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lit_q <= LIT_LAST)
    else $error("lit index out of LED range");

  a_off_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == lpbc_pkg::MODE_DARK && !man_en_q) |->
      (duty_q[0] == lpbc_pkg::DUTY_OFF && duty_q[1] == lpbc_pkg::DUTY_OFF &&
       duty_q[2] == lpbc_pkg::DUTY_OFF))
    else $error("off mode with LEDs lit");

  a_all_on_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == lpbc_pkg::MODE_FULL && !man_en_q) |->
      (duty_q[0] == lpbc_pkg::DUTY_ON && duty_q[1] == lpbc_pkg::DUTY_ON &&
       duty_q[2] == lpbc_pkg::DUTY_ON))
    else $error("all on mode with LEDs not full");

endmodule

// ===== hdl/lpbc_out_buf.sv =====
// Result register with a skid stage so a new tick is taken while a result waits.
module lpbc_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lpbc_pkg::res_t  res_i,
  output logic           ready_o,
  output logic           valid_o,
  input  logic           pop_ready_i,
  output lpbc_pkg::res_t  res_o
);

  logic           out_vld_q, out_vld_d;
  logic           skid_vld_q, skid_vld_d;
  lpbc_pkg::res_t out_q, out_d;
  lpbc_pkg::res_t skid_q, skid_d;
  logic           pop;

  assign pop     = out_vld_q && pop_ready_i;
  assign ready_o = !skid_vld_q;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (pop && skid_vld_q) begin
      out_d      = skid_q;
      skid_vld_d = 1'b0;
    end else if (pop || !out_vld_q) begin
      out_vld_d = push_i;
      out_d     = res_i;
    end else if (push_i) begin
      // output still waiting: park the new result
      skid_vld_d = 1'b1;
      skid_d     = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign valid_o = out_vld_q;
  assign res_o   = out_q;

endmodule

// ===== test/tb_led_pattern_button_controller.sv =====
// Self-checking testbench for the LED pattern and button controller: tick streams against a
// cycle-free predictor, with random idling on both stream sides and several register settings.
`timescale 1ns / 100ps

module tb_led_pattern_button_controller;

  localparam int unsigned WATCHDOG_LIMIT = 400;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned MAX_PRINTS     = 40;

  localparam lpbc_pkg::tick_t T_IDLE = 3'b000;
  localparam lpbc_pkg::tick_t T_MODE = 3'b001;
  localparam lpbc_pkg::tick_t T_ACT  = 3'b010;
  localparam lpbc_pkg::tick_t T_RST  = 3'b100;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata  = '0;  // mode, action, reset pressed
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [31:0]                     m_axis_tdata;  // red, green, yellow, buzzer_on, mode, override
  logic                            cfg_we_i      = 1'b0;
  logic [lpbc_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [lpbc_pkg::CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  led_pattern_button_controller u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register shadows, reset values.
  logic [9:0]  cfg_debounce = 10'd50;
  logic [15:0] cfg_long     = 16'd1500;
  logic [15:0] cfg_blink    = 16'd400;
  logic [15:0] cfg_buzz     = 16'd300;

  // Panel state as the block should hold it.
  lpbc_pkg::mode_e            st_mode      = lpbc_pkg::MODE_DARK;
  bit                         st_man_en    = 1'b0;
  bit                         st_man_lvl   = 1'b0;
  bit                         st_blink_ph  = 1'b0;
  bit                         st_held      = 1'b0;
  bit                         st_long_done = 1'b0;
  bit                         st_mode_wait = 1'b0;
  bit                         st_rst_wait  = 1'b0;
  logic [1:0]                 st_lit       = '0;
  logic [15:0]                st_blink_cnt = '0;
  logic [lpbc_pkg::PH_W-1:0]  st_fade_ph   = '0;
  logic [15:0]                st_hold_cnt  = '0;
  logic [15:0]                st_buzz_cnt  = '0;
  logic [lpbc_pkg::GAP_W-1:0] st_mode_gap  = lpbc_pkg::GAP_SAT;
  logic [lpbc_pkg::GAP_W-1:0] st_rst_gap   = lpbc_pkg::GAP_SAT;
  logic [7:0]                 st_duty [3]  = '{8'd0, 8'd0, 8'd0};

  lpbc_pkg::res_t pending_res[$];
  int unsigned    err_count     = 0;
  int unsigned    ticks_sent    = 0;
  int unsigned    results_seen  = 0;
  int unsigned    settings_used = 0;
  int unsigned    idle_cycles   = 0;

  int unsigned tx_stretch = 0;
  bit          tx_quiet   = 1'b0;
  int unsigned rx_stretch = 0;
  bit          rx_quiet   = 1'b0;
  int unsigned rx_hold    = 0;
  int unsigned rx_seen    = 0;

  function automatic longint unsigned quarter_wave(longint unsigned z);
    longint unsigned z2;
    longint unsigned t;
    z2 = (z * z) >> 15;
    t  = (64'd2320 * z2) >> 15;
    t  = ((64'd21024 - t) * z2) >> 15;
    return ((64'd51472 - t) * z) >> 15;
  endfunction

  function automatic logic [7:0] fade_level(int unsigned led);
    longint unsigned per;
    longint unsigned ofs;
    longint unsigned ph;
    longint unsigned ang;
    longint unsigned quad;
    longint unsigned frac;
    longint unsigned s;
    longint unsigned u;
    per  = lpbc_pkg::FADE_PERIOD_MS;
    ofs  = (longint'(led) * per * 2 + 3) / 6;
    ph   = (longint'(st_fade_ph) + ofs) % per;
    ang  = (ph * 131072) / per;
    quad = (ang >> 15) & 3;
    frac = ang & 32767;
    s    = quad[0] ? quarter_wave(64'd32768 - frac) : quarter_wave(frac);
    u    = quad[1] ? (64'd32768 - s) : (64'd32768 + s);
    return 8'((u * 255) >> 16);
  endfunction

  function automatic void set_duties(logic [7:0] v);
    for (int k = 0; k < 3; k++) st_duty[k] = v;
  endfunction

  function automatic void enter_mode(lpbc_pkg::mode_e m);
    st_mode   = m;
    st_man_en = 1'b0;
    case (m)
      lpbc_pkg::MODE_DARK: set_duties(lpbc_pkg::DUTY_OFF);
      lpbc_pkg::MODE_ALT: begin
        st_blink_cnt = '0;
        st_blink_ph  = 1'b0;
      end
      lpbc_pkg::MODE_FULL: set_duties(lpbc_pkg::DUTY_ON);
      default:             st_fade_ph = '0;
    endcase
  endfunction

  // One millisecond of panel behavior; returns the result the block should give.
  function automatic lpbc_pkg::res_t advance_panel(lpbc_pkg::tick_t t);
    lpbc_pkg::res_t r;
    if (st_mode_gap < lpbc_pkg::GAP_SAT) st_mode_gap++;
    if (st_rst_gap < lpbc_pkg::GAP_SAT) st_rst_gap++;
    if (st_blink_cnt != lpbc_pkg::CNT_MAX) st_blink_cnt++;
    st_fade_ph = lpbc_pkg::PH_W'((int'(st_fade_ph) + 1) % lpbc_pkg::FADE_PERIOD_MS);
    if (st_held && st_hold_cnt != lpbc_pkg::CNT_MAX) st_hold_cnt++;
    if (st_buzz_cnt != 0) st_buzz_cnt--;

    if (st_mode_wait) begin
      if (!t.mode_pressed) begin
        st_mode_wait = 1'b0;
        st_mode_gap  = '0;
      end
    end else if (t.mode_pressed && st_mode_gap > cfg_debounce) begin
      enter_mode(lpbc_pkg::mode_e'(2'(st_mode + 1)));
      st_mode_wait = 1'b1;
    end

    if (st_rst_wait) begin
      if (!t.reset_pressed) begin
        st_rst_wait = 1'b0;
        st_rst_gap  = '0;
      end
    end else if (t.reset_pressed && st_rst_gap > cfg_debounce) begin
      enter_mode(lpbc_pkg::MODE_DARK);
      st_rst_wait = 1'b1;
    end

    if (t.action_pressed && !st_held) begin
      st_held      = 1'b1;
      st_hold_cnt  = '0;
      st_long_done = 1'b0;
    end
    if (t.action_pressed && st_held && !st_long_done && st_hold_cnt >= cfg_long) begin
      st_long_done = 1'b1;
      st_buzz_cnt  = cfg_buzz;
    end
    if (!t.action_pressed && st_held) begin
      st_held = 1'b0;
      if (!st_long_done && st_hold_cnt < cfg_long) begin
        st_man_en  = 1'b1;
        st_man_lvl = !st_man_lvl;
        set_duties(st_man_lvl ? lpbc_pkg::DUTY_ON : lpbc_pkg::DUTY_OFF);
      end
    end

    if (!st_man_en) begin
      if (st_mode == lpbc_pkg::MODE_ALT) begin
        if (st_blink_cnt >= cfg_blink) begin
          st_blink_cnt = '0;
          st_blink_ph  = !st_blink_ph;
          if (st_blink_ph) begin
            st_lit = 2'((int'(st_lit) + 1) % lpbc_pkg::LED_COUNT);
            for (int k = 0; k < 3; k++) begin
              st_duty[k] = (st_lit == k) ? lpbc_pkg::DUTY_ON : lpbc_pkg::DUTY_OFF;
            end
          end else begin
            set_duties(lpbc_pkg::DUTY_OFF);
          end
        end
      end else if (st_mode == lpbc_pkg::MODE_SINE) begin
        for (int k = 0; k < 3; k++) st_duty[k] = fade_level(k);
      end
    end

    r.red_duty        = st_duty[0];
    r.green_duty      = st_duty[1];
    r.yellow_duty     = st_duty[2];
    r.buzzer_on       = (st_buzz_cnt != 0);
    r.current_mode    = st_mode;
    r.override_active = st_man_en;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned seen);
    if (err_count < MAX_PRINTS)
      $display("MISMATCH result %0d: %s expected %0d got %0d", results_seen, what, want, seen);
    err_count++;
  endtask

  // Result checker, sampled at the rising edge.
  always @(posedge clk_i) begin
    lpbc_pkg::res_t want;
    lpbc_pkg::res_t seen;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = lpbc_pkg::res_t'(m_axis_tdata[lpbc_pkg::RES_W-1:0]);
      if (pending_res.size() == 0) begin
        report_mismatch("result with no pending request, tdata", 0, m_axis_tdata);
      end else begin
        want = pending_res.pop_front();
        if (seen.red_duty !== want.red_duty)
          report_mismatch("red_duty", want.red_duty, seen.red_duty);
        if (seen.green_duty !== want.green_duty)
          report_mismatch("green_duty", want.green_duty, seen.green_duty);
        if (seen.yellow_duty !== want.yellow_duty)
          report_mismatch("yellow_duty", want.yellow_duty, seen.yellow_duty);
        if (seen.buzzer_on !== want.buzzer_on)
          report_mismatch("buzzer_on", want.buzzer_on, seen.buzzer_on);
        if (seen.current_mode !== want.current_mode)
          report_mismatch("current_mode", want.current_mode, seen.current_mode);
        if (seen.override_active !== want.override_active)
          report_mismatch("override_active", want.override_active, seen.override_active);
      end
      results_seen++;
    end
  end

  // Output backpressure: a random stall before each result, in stretches.
  always @(negedge clk_i) begin
    if (rx_seen != results_seen) begin
      rx_seen = results_seen;
      if (rx_stretch == 0) begin
        rx_stretch = $urandom_range(8, 40);
        rx_quiet   = ($urandom_range(0, 2) == 0);
      end
      rx_stretch--;
      rx_hold = rx_quiet ? 0 : $urandom_range(0, 6);
    end
    if (rx_hold != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no request moved for %0d cycles, %0d results pending",
                 idle_cycles, pending_res.size());
        $display("[led_pattern_button_controller] ERROR");
        $finish;
      end
    end
  end

  // Sends n ticks of one button pattern, each after a random gap.
  task automatic send_ticks(input lpbc_pkg::tick_t t, input int unsigned n);
    int unsigned gap;
    for (int unsigned i = 0; i < n; i++) begin
      if (tx_stretch == 0) begin
        tx_stretch = $urandom_range(8, 40);
        tx_quiet   = ($urandom_range(0, 2) == 0);
      end
      tx_stretch--;
      gap = tx_quiet ? 0 : $urandom_range(0, 6);
      @(negedge clk_i);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= 8'(t);
      do @(posedge clk_i); while (!s_axis_tready);
      pending_res.push_back(advance_panel(t));
      ticks_sent++;
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned dbc, input int unsigned lng,
                            input int unsigned blk, input int unsigned bz);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= lpbc_pkg::CFG_DEBOUNCE;
    cfg_wdata_i <= lpbc_pkg::CFG_DATA_W'(dbc);
    @(negedge clk_i);
    cfg_index_i <= lpbc_pkg::CFG_LONG;
    cfg_wdata_i <= lpbc_pkg::CFG_DATA_W'(lng);
    @(negedge clk_i);
    cfg_index_i <= lpbc_pkg::CFG_BLINK;
    cfg_wdata_i <= lpbc_pkg::CFG_DATA_W'(blk);
    @(negedge clk_i);
    cfg_index_i <= lpbc_pkg::CFG_BUZZ;
    cfg_wdata_i <= lpbc_pkg::CFG_DATA_W'(bz);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_debounce = 10'(dbc);
    cfg_long     = 16'(lng);
    cfg_blink    = 16'(blk);
    cfg_buzz     = 16'(bz);
    settings_used++;
  endtask

  // Button gestures: presses and releases with random lengths, plus some noise.
  task automatic random_ticks(input int unsigned n);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    int unsigned lo;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_ticks((pick < 25) ? T_MODE : T_RST, $urandom_range(1, 4));
        len = $urandom_range(0, (cfg_debounce + 3 > 40) ? 40 : cfg_debounce + 3);
        send_ticks(T_IDLE, len);
        sent += len + 2;
      end else if (pick < 65) begin
        // hold lengths cluster around the long-press threshold
        if ($urandom_range(0, 1)) begin
          len = $urandom_range(1, (cfg_long + 2 > 40) ? 40 : cfg_long + 2);
        end else begin
          lo  = (cfg_long > 1) ? cfg_long - 1 : 1;
          len = $urandom_range(lo, lo + 3);
          if (len > 60) len = 60;
        end
        send_ticks(T_ACT, len);
        send_ticks(T_IDLE, $urandom_range(1, 3));
        sent += len + 2;
      end else if (pick < 80) begin
        len = $urandom_range(1, (2 * cfg_blink + 2 > 30) ? 30 : 2 * cfg_blink + 2);
        send_ticks(T_IDLE, len);
        sent += len;
      end else begin
        len = $urandom_range(1, 6);
        for (int unsigned i = 0; i < len; i++) begin
          send_ticks(lpbc_pkg::tick_t'(3'($urandom_range(0, 7))), 1);
        end
        sent += len;
      end
    end
  endtask

  // Reset-value registers: reset beats mode in one tick, short action presses, debounce.
  task automatic test_directed_defaults();
    send_ticks(T_MODE | T_RST, 1);
    send_ticks(T_IDLE, 1);
    send_ticks(T_ACT, 1);
    send_ticks(T_IDLE, 1);
    send_ticks(T_MODE, 1);  // too soon after release, rejected
    send_ticks(T_IDLE, 1);
    send_ticks(T_ACT, 1);
    send_ticks(T_IDLE, 1);
    send_ticks(T_MODE | T_ACT | T_RST, 1);
    send_ticks(T_IDLE, 1);
  endtask

  // All time registers at zero: mode cycling every other tick, blink every tick,
  // long press on its first tick without a buzzer pulse.
  task automatic test_zero_times();
    set_config(0, 0, 0, 0);
    send_ticks(T_RST, 1);
    send_ticks(T_IDLE, 1);
    send_ticks(T_MODE, 1);
    send_ticks(T_IDLE, 3);
    send_ticks(T_MODE, 1);
    send_ticks(T_IDLE, 1);
    send_ticks(T_MODE, 1);
    send_ticks(T_IDLE, 1);
    send_ticks(T_MODE, 1);
    send_ticks(T_IDLE, 1);
    send_ticks(T_ACT, 2);
    send_ticks(T_IDLE, 1);
  endtask

  task automatic test_low_limits();
    set_config(0, 1, 1, 1);
    random_ticks(200);
  endtask

  // Long idle stretch in fade mode so the three phase-shifted LEDs cover the whole period,
  // then the largest register values.
  task automatic test_fade_sweep();
    set_config(0, 65535, 65535, 65535);
    while (st_mode != lpbc_pkg::MODE_SINE) begin
      send_ticks(T_MODE, 1);
      send_ticks(T_IDLE, 1);
    end
    send_ticks(T_IDLE, 700);
    set_config(1023, 65535, 65535, 65535);
    random_ticks(20);
  endtask

  task automatic test_random_settings();
    set_config(3, 8, 5, 6);
    random_ticks(300);
    repeat (2) begin
      set_config($urandom_range(0, 12), $urandom_range(1, 30), $urandom_range(1, 20),
                 $urandom_range(1, 25));
      random_ticks(150);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    test_directed_defaults();
    test_zero_times();
    test_low_limits();
    test_fade_sweep();
    test_random_settings();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Run covered %0d ticks under %0d register settings, %0d results compared.",
             ticks_sent, settings_used + 1, results_seen);
    $display("Mismatches counted: %0d", err_count);
    if (err_count == 0) begin
      $display("[led_pattern_button_controller] OK");
    end else begin
      $display("[led_pattern_button_controller] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lpbc_pkg.sv
hdl/lpbc_fade_rom.sv
hdl/lpbc_cfg_regs.sv
hdl/lpbc_core.sv
hdl/lpbc_out_buf.sv
hdl/led_pattern_button_controller.sv
test/tb_led_pattern_button_controller.sv
